@@ sv/wcac_pkg.sv @@
package wcac_pkg;

  localparam int unsigned WaveSlots = 64;
  localparam int unsigned SlotW = $clog2(WaveSlots);
  localparam int unsigned CntW = 48;
  localparam int unsigned NumCnt = 18;
  localparam int unsigned CntIdxW = 5;
  localparam int unsigned NumClasses = 9;
  localparam int unsigned QDepth = 2;

  typedef enum logic [2:0] {
    CMD_BEGIN    = 3'd0,
    CMD_WAIT     = 3'd1,
    CMD_RUNNABLE = 3'd2,
    CMD_COMPLETE = 3'd3,
    CMD_LAUNCH   = 3'd4,
    CMD_TICK     = 3'd5,
    CMD_READ     = 3'd6,
    CMD_NOP      = 3'd7
  } cmd_e;

  localparam logic [CntIdxW-1:0] CNT_CYCLES    = 5'd0;
  localparam logic [CntIdxW-1:0] CNT_WORK      = 5'd1;
  localparam logic [CntIdxW-1:0] CNT_CLASS     = 5'd2;
  localparam logic [CntIdxW-1:0] CNT_INSTS     = 5'd11;
  localparam logic [CntIdxW-1:0] CNT_SALU      = 5'd12;
  localparam logic [CntIdxW-1:0] CNT_VALU      = 5'd13;
  localparam logic [CntIdxW-1:0] CNT_TENSOR    = 5'd14;
  localparam logic [CntIdxW-1:0] CNT_BARRIER   = 5'd15;
  localparam logic [CntIdxW-1:0] CNT_LAUNCHED  = 5'd16;
  localparam logic [CntIdxW-1:0] CNT_COMPLETED = 5'd17;

  localparam logic [3:0] CLS_SALU    = 4'd0;
  localparam logic [3:0] CLS_VALU    = 4'd1;
  localparam logic [3:0] CLS_TENSOR  = 4'd2;
  localparam logic [3:0] CLS_BARRIER = 4'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_OUT
  } state_e;

  // decoded command passed from front end to back end
  typedef struct packed {
    cmd_e             cmd;
    logic             wave_ok;
    logic [SlotW-1:0] slot;
    logic [3:0]       cls;
    logic [31:0]      cost;
    logic [15:0]      weight;
    logic [CntIdxW-1:0] cidx;
  } op_t;

endpackage

@@ sv/wcac_front.sv @@
module wcac_front
  import wcac_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,
  output logic        op_valid_o,
  input  logic        op_ready_i,
  output op_t         op_o
);

  op_t  q_mem [QDepth];
  logic [0:0] wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  op_t  op_in;
  logic [5:0] wid;
  logic push, pop;

  // classify the incoming beat
  always_comb begin
    wid = s_axis_tdata[8:3];
    op_in.cmd = cmd_e'(s_axis_tdata[2:0]);
    op_in.wave_ok = ({26'd0, wid} < 32'(WaveSlots));
    op_in.slot = SlotW'(wid);
    op_in.cls = s_axis_tdata[12:9];
    op_in.cost = s_axis_tdata[44:13];
    op_in.weight = s_axis_tdata[60:45];
    op_in.cidx = s_axis_tdata[65:61];
  end

  assign s_axis_tready = (cnt_q != 2'(QDepth));
  assign push = s_axis_tvalid && s_axis_tready;
  assign op_valid_o = (cnt_q != 2'd0);
  assign pop = op_valid_o && op_ready_i;
  assign op_o = q_mem[rd_q];

  always_comb begin
    wr_d = push ? wr_q + 1'b1 : wr_q;
    rd_d = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  // small queue between the two halves
  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_q] <= op_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ sv/wcac_back.sv @@
module wcac_back
  import wcac_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        op_valid_i,
  output logic        op_ready_o,
  input  op_t         op_i,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata
);

  // slot state: flag bits in flops, payload in a memory
  logic [WaveSlots-1:0] present_q, present_d;
  logic [WaveSlots-1:0] active_q, active_d;
  logic [51:0] slot_mem [WaveSlots];   // {class, remaining, weight}
  logic [CntW-1:0] cnt_q [NumCnt];
  logic [$clog2(WaveSlots+1)-1:0] npres_q, npres_d;

  state_e state_q, state_d;
  logic [SlotW:0] sw_q, sw_d;          // sweep index, one extra bit
  logic   rd_vld_q;
  logic [SlotW-1:0] rd_slot_q;
  logic [51:0] rd_data_q;
  logic [CntW-1:0] val_q, val_d;
  logic   empty_q;
  logic   take;

  // memory port controls
  logic        mwe;
  logic [SlotW-1:0] mwa;
  logic [51:0] mwd;
  logic [SlotW-1:0] mra;
  logic        mre;

  logic [3:0]  r_cls;
  logic [31:0] r_rem;
  logic [15:0] r_wgt;
  logic        r_hit;
  logic        cmd_ok;

  assign take = op_valid_i && op_ready_o;
  assign op_ready_o = (state_q == ST_IDLE);
  assign r_cls = rd_data_q[51:48];
  assign r_rem = rd_data_q[47:16];
  assign r_wgt = rd_data_q[15:0];
  assign r_hit = rd_vld_q && present_q[rd_slot_q] && active_q[rd_slot_q] && (r_rem != 32'd0);
  assign cmd_ok = op_i.wave_ok;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (take) state_d = (op_i.cmd == CMD_TICK && npres_q != '0) ? ST_SWEEP : ST_OUT;
      ST_SWEEP: if (!mre && !rd_vld_q) state_d = ST_OUT;
      ST_OUT: if (m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sweep read address and table updates
  always_comb begin
    sw_d = sw_q;
    mre = 1'b0;
    mra = sw_q[SlotW-1:0];
    mwe = 1'b0;
    mwa = op_i.slot;
    mwd = {op_i.cls, op_i.cost, op_i.weight};
    present_d = present_q;
    active_d = active_q;
    val_d = val_q;
    if (state_q == ST_IDLE) sw_d = '0;
    if (state_q == ST_SWEEP && sw_q != (SlotW+1)'(WaveSlots)) begin
      mre = 1'b1;
      sw_d = sw_q + (SlotW+1)'(1);
    end
    if (r_hit) begin
      mwe = 1'b1;
      mwa = rd_slot_q;
      mwd = {r_cls, r_rem - 32'd1, r_wgt};
      if (r_rem == 32'd1) active_d[rd_slot_q] = 1'b0;
    end
    if (take) begin
      val_d = '0;
      case (op_i.cmd) inside
        CMD_BEGIN, CMD_WAIT: if (cmd_ok) begin
          if (op_i.cost == 32'd0) begin
            if (present_q[op_i.slot]) begin
              active_d[op_i.slot] = 1'b0;
              mwe = 1'b1;
              // class is don't-care while the slot is not active
              mwd = {op_i.cls, 32'd0, 16'd1};
            end
          end else begin
            present_d[op_i.slot] = 1'b1;
            active_d[op_i.slot] = 1'b1;
            mwe = 1'b1;
          end
        end
        CMD_RUNNABLE: if (cmd_ok && present_q[op_i.slot]) begin
          active_d[op_i.slot] = 1'b0;
          mwe = 1'b1;
          mwd = {op_i.cls, 32'd0, 16'd1};
        end
        CMD_COMPLETE: if (cmd_ok && present_q[op_i.slot]) begin
          present_d[op_i.slot] = 1'b0;
          active_d[op_i.slot] = 1'b0;
          mwe = 1'b1;
          mwd = {4'd0, 32'd0, 16'd1};
        end
        CMD_LAUNCH: if (cmd_ok) present_d[op_i.slot] = 1'b1;
        CMD_READ: if (op_i.cidx < CntIdxW'(NumCnt)) val_d = cnt_q[op_i.cidx];
        default: ;
      endcase
    end
  end

  // presence count for the empty flag
  always_comb begin
    npres_d = npres_q;
    if (take && cmd_ok) begin
      if ((op_i.cmd == CMD_LAUNCH ||
           ((op_i.cmd == CMD_BEGIN || op_i.cmd == CMD_WAIT) && op_i.cost != 32'd0))
          && !present_q[op_i.slot]) npres_d = npres_q + $bits(npres_q)'(1);
      if (op_i.cmd == CMD_COMPLETE && present_q[op_i.slot])
        npres_d = npres_q - $bits(npres_q)'(1);
    end
  end

  // slot memory, registered read
  always_ff @(posedge clk_i) begin
    if (mwe) slot_mem[mwa] <= mwd;
    if (mre) rd_data_q <= slot_mem[mra];
    rd_slot_q <= mra;
  end

  // statistics counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCnt; i++) cnt_q[i] <= '0;
    end else begin
      if (take && cmd_ok && op_i.cmd == CMD_BEGIN) begin
        cnt_q[CNT_INSTS] <= cnt_q[CNT_INSTS] + CntW'(1);
        case (op_i.cls)
          CLS_SALU:    cnt_q[CNT_SALU] <= cnt_q[CNT_SALU] + CntW'(1);
          CLS_VALU:    cnt_q[CNT_VALU] <= cnt_q[CNT_VALU] + CntW'(1);
          CLS_TENSOR:  cnt_q[CNT_TENSOR] <= cnt_q[CNT_TENSOR] + CntW'(1);
          CLS_BARRIER: cnt_q[CNT_BARRIER] <= cnt_q[CNT_BARRIER] + CntW'(1);
          default: ;
        endcase
      end
      if (take && cmd_ok && op_i.cmd == CMD_COMPLETE && present_q[op_i.slot])
        cnt_q[CNT_COMPLETED] <= cnt_q[CNT_COMPLETED] + CntW'(1);
      if (take && cmd_ok && op_i.cmd == CMD_LAUNCH)
        cnt_q[CNT_LAUNCHED] <= cnt_q[CNT_LAUNCHED] + CntW'(1);
      if (take && op_i.cmd == CMD_TICK && npres_q != '0)
        cnt_q[CNT_CYCLES] <= cnt_q[CNT_CYCLES] + CntW'(1);
      if (r_hit) begin
        cnt_q[CNT_WORK] <= cnt_q[CNT_WORK] + CntW'(r_wgt);
        if (r_cls < 4'(NumClasses))
          cnt_q[CNT_CLASS + CntIdxW'(r_cls)] <=
            cnt_q[CNT_CLASS + CntIdxW'(r_cls)] + CntW'(r_wgt);
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      present_q <= '0;
      active_q <= '0;
      npres_q <= '0;
      sw_q <= '0;
      rd_vld_q <= 1'b0;
      val_q <= '0;
      empty_q <= 1'b1;
    end else begin
      state_q <= state_d;
      present_q <= present_d;
      active_q <= active_d;
      npres_q <= npres_d;
      sw_q <= sw_d;
      rd_vld_q <= mre;
      val_q <= val_d;
      empty_q <= (npres_d == '0);
    end
  end

  // result beat
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata = {7'd0, empty_q, val_q};

endmodule

@@ sv/wave_cycle_accounting_counters.sv @@
// A command moves from the input queue into the back end while it is idle, and its
// result beat is held until accepted; a tick with waves present first sweeps the
// slot memory (one slot per cycle). One command is processed at a time, and the
// next is taken only after the result beat is accepted; a two-entry queue lets the input take beats early.
// Reset: async active low clears flags, counters and control; slot memory
// payload is rewritten by begin or wait before a slot can become active.
module wave_cycle_accounting_counters
  import wcac_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd, wave_id, op class, cost, weight, counter_index
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // counter_value, table_empty
  output logic [55:0] m_axis_tdata
);

  op_t  op;
  logic op_valid, op_ready;

  wcac_front u_front (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .op_valid_o(op_valid), .op_ready_i(op_ready), .op_o(op)
  );

  wcac_back u_back (
    .clk_i, .rst_ni, .op_valid_i(op_valid), .op_ready_o(op_ready), .op_i(op),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

endmodule

@@ dv/tb_top.sv @@
module tb_top;
  import wcac_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // cmd[2:0], wave_id[8:3], op class[12:9], cost[44:13],
  // weight[60:45], counter_index[65:61], zero fill[71:66]
  logic [71:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // counter_value[47:0], table_empty[48], zero fill[55:49]
  logic [55:0] m_axis_tdata;

  wave_cycle_accounting_counters DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  typedef struct packed {
    logic [47:0] value;
    logic        empty;
  } acct_result_t;

  // predictor state
  logic        wave_present [WaveSlots];
  logic        wave_active  [WaveSlots];
  logic [3:0]  wave_class   [WaveSlots];
  logic [31:0] wave_left    [WaveSlots];
  logic [15:0] wave_weight  [WaveSlots];
  logic [47:0] stat_cnt     [NumCnt];

  acct_result_t expected_q[$];
  int unsigned  n_sent, n_checked, n_errors, n_ticks, n_reads;
  int unsigned  idle_cycles;
  bit           sender_done;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic table_empty_now();
    for (int s = 0; s < WaveSlots; s++) begin
      if (wave_present[s]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void bump(int idx, logic [47:0] amt);
    stat_cnt[idx] = stat_cnt[idx] + amt;
  endfunction

  function automatic void clear_wave(int s);
    wave_present[s] = 1'b0;
    wave_active[s]  = 1'b0;
    wave_class[s]   = 4'd0;
    wave_left[s]    = 32'd0;
    wave_weight[s]  = 16'd1;
  endfunction

  function automatic void go_runnable(int s);
    wave_active[s] = 1'b0;
    wave_left[s]   = 32'd0;
    wave_weight[s] = 16'd1;
  endfunction

  function automatic void give_work(int s, logic [3:0] cls, logic [31:0] cost,
                                    logic [15:0] wt);
    if (cost == 0) begin
      if (wave_present[s]) go_runnable(s);
    end else begin
      wave_present[s] = 1'b1;
      wave_active[s]  = 1'b1;
      wave_class[s]   = cls;
      wave_left[s]    = cost;
      wave_weight[s]  = wt;
    end
  endfunction

  // advances the accounting state by one command, returns the result
  function automatic acct_result_t account_cmd(cmd_e cmd, logic [5:0] wid,
                                               logic [3:0] cls, logic [31:0] cost,
                                               logic [15:0] wt, logic [4:0] cidx);
    acct_result_t r;
    r.value = '0;
    case (cmd)
      CMD_BEGIN: begin
        give_work(wid, cls, cost, wt);
        bump(CNT_INSTS, 48'd1);
        case (cls)
          CLS_SALU:    bump(CNT_SALU, 48'd1);
          CLS_VALU:    bump(CNT_VALU, 48'd1);
          CLS_TENSOR:  bump(CNT_TENSOR, 48'd1);
          CLS_BARRIER: bump(CNT_BARRIER, 48'd1);
          default: ;
        endcase
      end
      CMD_WAIT: give_work(wid, cls, cost, wt);
      CMD_RUNNABLE: if (wave_present[wid]) go_runnable(wid);
      CMD_COMPLETE: begin
        if (wave_present[wid]) begin
          bump(CNT_COMPLETED, 48'd1);
          clear_wave(wid);
        end
      end
      CMD_LAUNCH: begin
        wave_present[wid] = 1'b1;
        bump(CNT_LAUNCHED, 48'd1);
      end
      CMD_TICK: begin
        if (!table_empty_now()) begin
          bump(CNT_CYCLES, 48'd1);
          for (int s = 0; s < WaveSlots; s++) begin
            if (wave_present[s] && wave_active[s] && wave_left[s] != 0) begin
              bump(CNT_WORK, wave_weight[s]);
              if (wave_class[s] < NumClasses)
                bump(CNT_CLASS + wave_class[s], wave_weight[s]);
              wave_left[s]--;
              if (wave_left[s] == 0) wave_active[s] = 1'b0;
            end
          end
        end
      end
      CMD_READ: if (cidx < NumCnt) r.value = stat_cnt[cidx];
      default: ;
    endcase
    r.empty = table_empty_now();
    return r;
  endfunction

  // send one command beat after a random gap; valid stays up for a following beat
  task automatic send_cmd(cmd_e cmd, logic [5:0] wid, logic [3:0] cls,
                          logic [31:0] cost, logic [15:0] wt, logic [4:0] cidx,
                          bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {6'd0, cidx, wt, cost, cls, wid, cmd};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(account_cmd(cmd, wid, cls, cost, wt, cidx));
    n_sent++;
    if (cmd == CMD_TICK) n_ticks++;
    if (cmd == CMD_READ) n_reads++;
  endtask

  task automatic read_all();
    for (int i = 0; i < 20; i++)
      send_cmd(CMD_READ, 6'($urandom), 4'($urandom), $urandom, 16'($urandom), 5'(i),
               1);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // directed: every command, field extremes, special cases
  task automatic test_directed();
    send_cmd(CMD_TICK, 6'd0, 4'd0, 32'd0, 16'd0, 5'd0);         // tick on empty table
    send_cmd(CMD_RUNNABLE, 6'd5, 4'd0, 32'd0, 16'd0, 5'd0);     // absent wave
    send_cmd(CMD_COMPLETE, 6'd5, 4'd0, 32'd0, 16'd0, 5'd0);
    send_cmd(CMD_BEGIN, 6'd9, 4'd3, 32'd0, 16'hffff, 5'd0);     // zero cost, absent
    send_cmd(CMD_LAUNCH, 6'd63, 4'd0, 32'd0, 16'd0, 5'd0);
    send_cmd(CMD_LAUNCH, 6'd63, 4'd0, 32'd0, 16'd0, 5'd0);      // already present
    send_cmd(CMD_BEGIN, 6'd63, 4'd15, 32'hffff_ffff, 16'hffff, 5'd31);
    send_cmd(CMD_WAIT, 6'd0, 4'd8, 32'd2, 16'd0, 5'd0);
    send_cmd(CMD_BEGIN, 6'd1, 4'd7, 32'd1, 16'd7, 5'd0);
    send_cmd(CMD_BEGIN, 6'd2, 4'd0, 32'd3, 16'd1, 5'd0);
    send_cmd(CMD_BEGIN, 6'd3, 4'd1, 32'd3, 16'd2, 5'd0);
    send_cmd(CMD_BEGIN, 6'd4, 4'd2, 32'd3, 16'd3, 5'd0);
    send_cmd(CMD_TICK, 6'd0, 4'd0, 32'd0, 16'd0, 5'd0);
    send_cmd(CMD_TICK, 6'd0, 4'd0, 32'd0, 16'd0, 5'd0);
    send_cmd(CMD_BEGIN, 6'd2, 4'd0, 32'd0, 16'd0, 5'd0);        // zero cost, present
    send_cmd(CMD_RUNNABLE, 6'd3, 4'd0, 32'd0, 16'd0, 5'd0);
    send_cmd(CMD_TICK, 6'd0, 4'd0, 32'd0, 16'd0, 5'd0);
    send_cmd(CMD_NOP, 6'h3f, 4'hf, 32'hffff_ffff, 16'hffff, 5'h1f);
    read_all();
    for (int s = 0; s < WaveSlots; s++)
      send_cmd(CMD_COMPLETE, 6'(s), 4'd0, 32'd0, 16'd0, 5'd0, 1);
    send_cmd(CMD_TICK, 6'd0, 4'd0, 32'd0, 16'd0, 5'd0);
    read_all();
  endtask

  // random: mostly well-formed wave lifetimes with ticks, plus noise
  task automatic test_random(int n_items);
    cmd_e       cmd;
    logic [5:0] wid;
    logic [3:0] cls;
    logic [31:0] cost;
    int         pick;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      wid  = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
      cls  = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8));
      case ($urandom_range(0, 5))
        0: cost = 32'd0;
        1: cost = $urandom;
        2: cost = 32'hffff_ffff;
        default: cost = $urandom_range(1, 6);
      endcase
      if (pick < 25) cmd = CMD_BEGIN;
      else if (pick < 33) cmd = CMD_WAIT;
      else if (pick < 38) cmd = CMD_RUNNABLE;
      else if (pick < 45) cmd = CMD_COMPLETE;
      else if (pick < 52) cmd = CMD_LAUNCH;
      else if (pick < 75) cmd = CMD_TICK;
      else if (pick < 97) cmd = CMD_READ;
      else cmd = CMD_NOP;
      send_cmd(cmd, wid, cls, cost, 16'($urandom), 5'($urandom_range(0, 19)));
      if (i == n_items / 2) wait_drained();   // sender holds off until drained
    end
  endtask

  // large weights and long costs to drive up the work and class counters
  task automatic test_heavy_load();
    for (int s = 0; s < 16; s++)
      send_cmd(CMD_BEGIN, 6'(s), 4'(s % 9), 32'hffff_ffff, 16'hffff, 5'd0, 1);
    repeat (40) send_cmd(CMD_TICK, 6'd0, 4'd0, 32'd0, 16'd0, 5'd0, 1);
    read_all();
  endtask

  // result checker with random receiver stalls
  initial begin
    acct_result_t got, exp;
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.value = m_axis_tdata[47:0];
      got.empty = m_axis_tdata[48];
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("ERROR: unexpected beat %h", m_axis_tdata);
      end else begin
        exp = expected_q.pop_front();
        n_checked++;
        if (got !== exp) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: result %0d value exp %h got %h, empty exp %b got %b",
                     n_checked, exp.value, got.value, exp.empty, got.empty);
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("wave_cycle_accounting_counters verification failed");
      $finish;
    end
  end

  initial begin
    int tail;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni        = 1'b0;
    idle_cycles   = 0;
    for (int s = 0; s < WaveSlots; s++) clear_wave(s);
    for (int c = 0; c < NumCnt; c++) stat_cnt[c] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1400);
    test_heavy_load();
    wait_drained();
    tail = 0;
    while (tail < 200 && !m_axis_tvalid) begin
      @(posedge clk_i);
      tail++;
    end
    if (m_axis_tvalid) begin
      n_errors++;
      $display("ERROR: extra result beat after drain");
    end
    $display("Sent %0d commands (%0d ticks, %0d counter reads), checked %0d results.",
             n_sent, n_ticks, n_reads, n_checked);
    if (n_errors == 0) begin
      $display("wave_cycle_accounting_counters verification clean");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("wave_cycle_accounting_counters verification failed");
    end
    $finish;
  end

endmodule
